[rtl/cgf_pkg.sv]
// Shared types and constants of the corner gradient filter.
`default_nettype none

package cgf_pkg;

	localparam int PIX_W           = 8;
	localparam int IMG_WIDTH_BITS  = 11;
	localparam int IMG_HEIGHT_BITS = 13;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [IMG_WIDTH_BITS-1:0]  WIDTH_RESET  = IMG_WIDTH_BITS'(512);
	localparam logic [IMG_HEIGHT_BITS-1:0] HEIGHT_RESET = IMG_HEIGHT_BITS'(512);

	localparam logic [PIX_W-1:0] GRAD_MAX = 8'd255;

	// One window column: pixels of the row two above, one above and the current row.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} column_t;

	// Emit/last flags and the kernel taps inside the image for the pixel being finished.
	typedef struct packed {
		logic emit;
		logic last;
		logic up_ok;
		logic down_ok;
		logic left_ok;
		logic right_ok;
	} tap_mask_t;

endpackage

`default_nettype wire

[rtl/cgf_ifs.sv]
// Stream and configuration channel interfaces of the corner gradient filter.
`default_nettype none

interface cgf_pix_if import cgf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             drain;

	modport source (output valid, output pixel, output drain, input ready);
	modport sink   (input valid, input pixel, input drain, output ready);
endinterface

interface cgf_res_if import cgf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] gradient;
	logic             last_of_frame;

	modport source (output valid, output gradient, output last_of_frame, input ready);
	modport sink   (input valid, input gradient, input last_of_frame, output ready);
endinterface

interface cgf_cfg_if import cgf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/cgf_line_buf.sv]
// Line buffer memory with one write and one registered read port.
`default_nettype none

module cgf_line_buf #(
	parameter int DEPTH = 1024,
	parameter int DW    = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read of the entry being written in the same cycle takes the new data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/cgf_cell.sv]
// One window cell: holds a pixel column and passes it on to its neighbor.
`default_nettype none

module cgf_cell import cgf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    shift_en,
	input  wire column_t col_in,
	output column_t      col_out
);

	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

[rtl/corner_gradient_filter_3x3.sv]
// Top level of the 3x3 corner gradient filter over a raster pixel stream.
// One beat per cycle unless the output stalls; line buffer read once per taken beat.
// A result is computed in stage 1 from the beat that completes its window, which is the
// beat image_width+1 positions after the pixel itself, then held in the output register.
// Reset clears the position, the window cells and the output, and sets a 512x512 frame.
// Line buffer contents are not cleared; rows not yet written in a frame are masked out.
`default_nettype none

module corner_gradient_filter_3x3 import cgf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cgf_pix_if.sink   pixels,
	cgf_res_if.source results,
	cgf_cfg_if.sink   cfg
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = XW + 1;
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	logic [IMG_WIDTH_BITS-1:0]  width_q;
	logic [IMG_HEIGHT_BITS-1:0] height_q;
	logic [WW-1:0]              eff_w;
	logic [RW-1:0]              eff_h;

	logic [XW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          cfg_wr;
	logic          accept;
	logic          take;
	logic          en;
	logic          col_last;
	tap_mask_t     mask;
	logic [PIX_W-1:0] pix_v;

	logic             s1_v;
	tap_mask_t        mask_s1;
	logic [PIX_W-1:0] v_s1;
	logic [XW-1:0]    addr_s1;
	logic [2*PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;

	column_t new_col;
	column_t win_near;
	column_t win_far;

	logic [PIX_W+1:0]  pos_sum;
	logic [PIX_W+1:0]  neg_sum;
	logic signed [PIX_W+2:0] sum;
	logic [PIX_W-1:0]  grad;

	logic             out_v_q;
	logic [PIX_W-1:0] gradient_q;
	logic             last_q;

	// Configuration registers; the channel is always ready.
	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid && (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_IMAGE_WIDTH) begin
				width_q <= cfg.data[IMG_WIDTH_BITS-1:0];
			end
			if (cfg.index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg.data[IMG_HEIGHT_BITS-1:0];
			end
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = RW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = RW'(MAX_HEIGHT);
		end else begin
			eff_h = RW'(height_q);
		end
	end

	// Input side: the position of the incoming beat decides which taps are valid.
	assign en     = !out_v_q || results.ready;
	assign pixels.ready = !s1_v || en;
	assign accept = pixels.valid && pixels.ready;
	// A drain beat at the frame origin is dropped without touching any state.
	assign take   = accept && !(pixels.drain && col_q == '0 && row_q == '0);
	assign pix_v  = pixels.drain ? '0 : pixels.pixel;
	assign col_last = ({1'b0, col_q} == eff_w - WW'(1));

	always_comb begin
		if (col_q != '0) begin
			mask.emit     = (row_q != '0) && (row_q <= eff_h);
			mask.last     = 1'b0;
			mask.up_ok    = row_q >= RW'(2);
			mask.down_ok  = row_q < eff_h;
			mask.left_ok  = col_q >= XW'(2);
			mask.right_ok = 1'b1;
		end else begin
			// First column: the beat finishes the last pixel of the row before.
			mask.emit     = (row_q >= RW'(2)) && (row_q <= eff_h + RW'(1));
			mask.last     = (row_q == eff_h + RW'(1));
			mask.up_ok    = row_q >= RW'(3);
			mask.down_ok  = row_q <= eff_h;
			mask.left_ok  = eff_w >= WW'(2);
			mask.right_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (mask.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_last) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// Stage 1: line buffer data arrives; the window shifts when the stage moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (pixels.ready) begin
			s1_v <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mask_s1 <= mask;
			v_s1    <= pix_v;
			addr_s1 <= col_q;
		end
	end

	cgf_line_buf #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PIX_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_v && en),
		.wr_addr (addr_s1),
		.wr_data ({mid_s1, v_s1})
	);

	assign top_s1 = rd_data[2*PIX_W-1:PIX_W];
	assign mid_s1 = rd_data[PIX_W-1:0];

	assign new_col.top = top_s1;
	assign new_col.mid = mid_s1;
	assign new_col.bot = v_s1;

	cgf_cell u_cell_near (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_v && en),
		.col_in   (new_col),
		.col_out  (win_near)
	);

	cgf_cell u_cell_far (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_v && en),
		.col_in   (win_near),
		.col_out  (win_far)
	);

	// Corner kernel: the far column carries weight -2, the incoming column +2.
	always_comb begin
		pos_sum = '0;
		neg_sum = '0;
		if (mask_s1.right_ok) begin
			if (mask_s1.up_ok) begin
				pos_sum = pos_sum + {1'b0, top_s1, 1'b0};
			end
			if (mask_s1.down_ok) begin
				pos_sum = pos_sum + {1'b0, v_s1, 1'b0};
			end
		end
		if (mask_s1.left_ok) begin
			if (mask_s1.up_ok) begin
				neg_sum = neg_sum + {1'b0, win_far.top, 1'b0};
			end
			if (mask_s1.down_ok) begin
				neg_sum = neg_sum + {1'b0, win_far.bot, 1'b0};
			end
		end
		sum = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
		if (sum < 0) begin
			grad = '0;
		end else if (sum > $signed({3'b000, GRAD_MAX})) begin
			grad = GRAD_MAX;
		end else begin
			grad = sum[PIX_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= s1_v && mask_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s1_v && mask_s1.emit) begin
			gradient_q <= grad;
			last_q     <= mask_s1.last;
		end
	end

	assign results.valid         = out_v_q;
	assign results.gradient      = gradient_q;
	assign results.last_of_frame = last_q;

endmodule

`default_nettype wire

[rtl/cgf_checker.sv]
// Port-level assertions for the corner gradient filter, bound to its top level.
`default_nettype none

module cgf_port_checks import cgf_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] gradient,
	input wire logic             last_of_frame
);

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gradient) && $stable(last_of_frame))
		else $error("result beat changed while stalled");

	// With the output register empty, the input side never stalls.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	// Every frame spans at least three beats, so two frame ends never follow each other.
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_frame |=> !(out_valid && last_of_frame))
		else $error("two consecutive end-of-frame results");

endmodule

bind corner_gradient_filter_3x3 cgf_port_checks u_cgf_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (pixels.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.gradient      (results.gradient),
	.last_of_frame (results.last_of_frame)
);

`default_nettype wire

[tb/cgf_checker.sv]
// Scoreboard of the corner gradient filter: predicts every gradient beat and compares it.
module cgf_checker import cgf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	cgf_pix_if   pixels,
	cgf_res_if   results,
	cgf_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] gradient;
		logic             last_of_frame;
	} gradient_beat_t;

	gradient_beat_t gradients_due[$];

	logic [PIX_W-1:0]           two_up_row [MAX_WIDTH];
	logic [PIX_W-1:0]           one_up_row [MAX_WIDTH];
	// Entries 0..2 hold the column two left of the incoming pixel, 3..5 the one just left.
	logic [PIX_W-1:0]           window [6];
	int                         col_pos;
	int                         row_pos;
	logic [IMG_WIDTH_BITS-1:0]  width_reg;
	logic [IMG_HEIGHT_BITS-1:0] height_reg;

	task automatic flag_error(input string msg);
		$display("checker: %s at %0t", msg, $time);
		errors++;
	endtask

	function automatic int clamp_dim(input int val, input int ceiling);
		if (val == 0) begin
			return 1;
		end
		return (val > ceiling) ? ceiling : val;
	endfunction

	task automatic advance_filter(input logic [PIX_W-1:0] pix_in, input logic drain_in);
		int               w;
		int               h;
		int               x;
		int               r;
		int               xo;
		int               yo;
		int               acc;
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		tap_mask_t        taps;
		gradient_beat_t   beat;

		w = clamp_dim(int'(width_reg), MAX_WIDTH);
		h = clamp_dim(int'(height_reg), MAX_HEIGHT);
		v = drain_in ? '0 : pix_in;
		if (col_pos >= w || row_pos > h + 1) begin
			col_pos = 0;
			row_pos = 0;
		end
		x = col_pos;
		r = row_pos;
		// A flush beat with no frame in progress leaves everything untouched.
		if (drain_in && x == 0 && r == 0) begin
			return;
		end

		top = two_up_row[x];
		mid = one_up_row[x];
		if (x >= 1) begin
			xo = x - 1;
			yo = r - 1;
		end else begin
			xo = w - 1;
			yo = r - 2;
		end

		taps = '0;
		taps.emit = (yo >= 0) && (yo < h);
		taps.last = taps.emit && (xo == w - 1) && (yo == h - 1);
		if (taps.emit) begin
			taps.up_ok    = yo >= 1;
			taps.down_ok  = yo + 1 < h;
			taps.left_ok  = xo >= 1;
			taps.right_ok = xo + 1 < w;
			acc = 0;
			if (taps.left_ok && taps.up_ok) acc -= 2 * int'(window[0]);
			if (taps.left_ok && taps.down_ok) acc -= 2 * int'(window[2]);
			if (taps.right_ok && taps.up_ok) acc += 2 * int'(top);
			if (taps.right_ok && taps.down_ok) acc += 2 * int'(v);
			if (acc < 0) acc = 0;
			if (acc > int'(GRAD_MAX)) acc = int'(GRAD_MAX);
			beat.gradient      = PIX_W'(acc);
			beat.last_of_frame = taps.last;
			gradients_due.push_back(beat);
		end

		two_up_row[x] = mid;
		one_up_row[x] = v;
		window[0] = window[3];
		window[1] = window[4];
		window[2] = window[5];
		window[3] = top;
		window[4] = mid;
		window[5] = v;

		if (taps.last) begin
			col_pos = 0;
			row_pos = 0;
		end else begin
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
	endtask

	task automatic check_result(input logic [PIX_W-1:0] grad, input logic last);
		gradient_beat_t want;

		if (gradients_due.size() == 0) begin
			flag_error($sformatf("gradient %0d (last %b) with nothing expected", grad, last));
			return;
		end
		want = gradients_due.pop_front();
		if (grad !== want.gradient) begin
			flag_error($sformatf("gradient %0d, expected %0d", grad, want.gradient));
		end
		if (last !== want.last_of_frame) begin
			flag_error($sformatf("last_of_frame %b, expected %b", last, want.last_of_frame));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos    = 0;
			row_pos    = 0;
			foreach (two_up_row[i]) begin
				two_up_row[i] = '0;
				one_up_row[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			gradients_due.delete();
		end else begin
			// Output first, so a beat can never match an expectation queued on the same edge.
			if (results.valid && results.ready) begin
				check_result(results.gradient, results.last_of_frame);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_IMAGE_WIDTH: begin
					width_reg = cfg.data[IMG_WIDTH_BITS-1:0];
					col_pos   = 0;
					row_pos   = 0;
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = cfg.data[IMG_HEIGHT_BITS-1:0];
					col_pos    = 0;
					row_pos    = 0;
				end
				default: ;
				endcase
			end
			if (pixels.valid && pixels.ready) begin
				advance_filter(pixels.pixel, pixels.drain);
			end
		end
		pending = gradients_due.size();
	end

endmodule

[tb/tb.sv]
// Stimulus and verdict for the corner gradient filter: directed frames, random frames, extremes.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cgf_pkg::*;

	localparam int RANDOM_ITEMS   = 380;
	localparam int SETTLE_CYCLES  = 12;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int FRAME_W_MAX    = 1024;
	localparam int FRAME_H_MAX    = 4096;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP = '1;

	// Directed beats, coded as {drain, pixel}.
	localparam logic [8:0] WARMUP [4] = '{9'h1A5, 9'h0FF, 9'h100, 9'h000};
	localparam logic [8:0] FRAME_A [10] = '{
		9'h0FF, 9'h000, 9'h0FF,
		9'h000, 9'h0FF, 9'h000,
		9'h100, 9'h080, 9'h100, 9'h100
	};
	localparam logic [8:0] FRAME_B [11] = '{
		9'h1FF,
		9'h0FF, 9'h0FF, 9'h000,
		9'h0FF, 9'h100, 9'h001,
		9'h100, 9'h100, 9'h100, 9'h100
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   due_count;
	int   items_sent;
	int   frame_w;
	int   frame_h;
	bit   steady;
	bit   squeeze_req;

	cgf_pix_if pix_bus ();
	cgf_res_if res_bus ();
	cgf_cfg_if cfg_bus ();

	corner_gradient_filter_3x3 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_bus),
		.results(res_bus),
		.cfg    (cfg_bus)
	);

	cgf_checker chk (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_bus),
		.results(res_bus),
		.cfg    (cfg_bus),
		.errors (fail_count),
		.pending(due_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;

		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic int effective_dim(input int field, input int ceiling);
		if (field == 0) begin
			return 1;
		end
		return (field > ceiling) ? ceiling : field;
	endfunction

	task automatic push_item(input logic [PIX_W-1:0] pix, input logic is_drain);
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			pix_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_bus.valid <= 1'b1;
		pix_bus.pixel <= pix;
		pix_bus.drain <= is_drain;
		do @(posedge clk); while (!pix_bus.ready);
	endtask

	task automatic hold_for_results();
		@(negedge clk);
		pix_bus.valid <= 1'b0;
		wait (due_count == 0);
	endtask

	// Beats that yield no gradient may still be in the pipeline after the last result.
	task automatic quiesce();
		hold_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_frame(input int w_field, input int h_field);
		logic [CFG_DATA_W-1:0] wd;
		logic [CFG_DATA_W-1:0] hd;

		wd = CFG_DATA_W'($urandom);
		hd = CFG_DATA_W'($urandom);
		wd[IMG_WIDTH_BITS-1:0]  = IMG_WIDTH_BITS'(w_field);
		hd[IMG_HEIGHT_BITS-1:0] = IMG_HEIGHT_BITS'(h_field);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_IMAGE_WIDTH, wd);
			write_reg(REG_IMAGE_HEIGHT, hd);
		end else begin
			write_reg(REG_IMAGE_HEIGHT, hd);
			write_reg(REG_IMAGE_WIDTH, wd);
		end
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_IMAGE_HEIGHT) + 1, int'(CFG_INDEX_TOP))),
				CFG_DATA_W'($urandom));
		end
		frame_w = effective_dim(w_field, FRAME_W_MAX);
		frame_h = effective_dim(h_field, FRAME_H_MAX);
	endtask

	// Sends the first cut_at beats of a frame: mostly pixels in the body, then mostly flush beats.
	task automatic run_frame(input int cut_at, input int squeeze_at, input int pause_at);
		int   body;
		logic is_drain;

		body = frame_w * frame_h;
		for (int k = 0; k < cut_at; k++) begin
			if (k == squeeze_at) squeeze_req = 1'b1;
			if (k == pause_at) hold_for_results();
			if (k < body) begin
				is_drain = ($urandom_range(0, 11) == 0);
			end else begin
				is_drain = ($urandom_range(0, 5) != 0);
			end
			push_item(pick_pixel(), is_drain);
		end
		items_sent += cut_at;
	endtask

	initial begin
		int run_left;

		res_bus.ready = 1'b0;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				res_bus.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
				squeeze_req = 1'b0;
				run_left = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				res_bus.ready <= 1'b1;
				run_left = $urandom_range(0, 15);
			end else begin
				res_bus.ready <= 1'b0;
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			end
		end
	end

	initial begin
		int frame_no;
		int w_field;
		int h_field;
		int total;
		int cut_at;
		bit broken;

		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		pix_bus.drain = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data  = '0;
		steady        = 1'b0;
		squeeze_req   = 1'b0;
		items_sent    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default 512-wide frame: an idle flush beat, a pixel, a flush inside the frame, a pixel.
		foreach (WARMUP[i]) push_item(WARMUP[i][7:0], WARMUP[i][8]);
		quiesce();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		write_reg(CFG_INDEX_TOP, '1);
		frame_w = 3;
		frame_h = 2;
		// Full 3x2 frames back to back; the first has a pixel among its flush beats.
		foreach (FRAME_A[i]) push_item(FRAME_A[i][7:0], FRAME_A[i][8]);
		foreach (FRAME_B[i]) push_item(FRAME_B[i][7:0], FRAME_B[i][8]);

		frame_no = 0;
		broken   = 1'b0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			if (frame_no == 0) begin
				quiesce();
				set_frame(5, 10);
			end else if (broken || $urandom_range(0, 2) != 0) begin
				quiesce();
				case ($urandom_range(0, 19))
				0: w_field = 0;
				1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: w_field = $urandom_range(1, 8);
				13, 14, 15, 16, 17: w_field = $urandom_range(9, 40);
				default: w_field = $urandom_range(41, 100);
				endcase
				case ($urandom_range(0, 19))
				0: h_field = 0;
				1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: h_field = $urandom_range(1, 6);
				default: h_field = $urandom_range(7, 20);
				endcase
				if (effective_dim(w_field, FRAME_W_MAX) * h_field > 300) begin
					h_field = 300 / effective_dim(w_field, FRAME_W_MAX);
				end
				set_frame(w_field, h_field);
			end
			// A flush beat between frames is dropped by the block.
			if ($urandom_range(0, 5) == 0) push_item(pick_pixel(), 1'b1);
			total  = frame_w * frame_h + frame_w + 1;
			broken = (frame_no != 0) && ($urandom_range(0, 6) == 0);
			cut_at = broken ? $urandom_range(1, total - 1) : total;
			if (frame_no == 0) begin
				run_frame(cut_at, 12, 30);
			end else begin
				run_frame(cut_at, -1,
					($urandom_range(0, 24) == 0) ? $urandom_range(0, cut_at - 1) : -1);
			end
			frame_no++;
		end

		// Largest sizes, cut short: a clamped width past its first row, then a clamped height.
		steady = 1'b0;
		quiesce();
		set_frame(2047, 0);
		run_frame(FRAME_W_MAX + 24, -1, -1);
		quiesce();
		set_frame(1, 8191);
		run_frame(80, -1, -1);

		hold_for_results();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && due_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule

[sim.f]
rtl/cgf_pkg.sv
rtl/cgf_ifs.sv
rtl/cgf_line_buf.sv
rtl/cgf_cell.sv
rtl/corner_gradient_filter_3x3.sv
rtl/cgf_checker.sv
tb/cgf_checker.sv
tb/tb.sv
